[rtl/core/btc_pkg.sv]
// Shared types and constants for the barometer trim compensation block.
// No dependencies; used by btc_front, btc_div and the top level.
package btc_pkg;

    // unpacked trim words
    typedef struct packed {
        logic        [15:0] t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic        [15:0] p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
    } t_trim;

    // results that ride alongside the pressure divide
    typedef struct packed {
        logic signed [14:0] tcs;
        logic signed [31:0] tfine;
        logic               zero;
    } t_side;

    localparam int FRONT_STAGES = 10;
    localparam int DIV_STEPS    = 64;
    localparam int POST_STAGES  = 6;

    localparam logic [7:0] CFG_TEMP_TRIM  = 8'd0;
    localparam logic [7:0] CFG_PRESS_LOW  = 8'd1;
    localparam logic [7:0] CFG_PRESS_HIGH = 8'd2;
    localparam logic [7:0] CFG_PRESS_LAST = 8'd3;

    localparam logic signed [14:0] TEMP_MIN     = -15'sd4000;
    localparam logic signed [14:0] TEMP_MAX     = 15'sd8500;
    localparam logic signed [24:0] TFINE_OFFSET = 25'sd128000;
    localparam logic signed [63:0] V1_BIAS      = 64'sh0000_8000_0000_0000;
    localparam logic [20:0]        PRESS_FULL   = 21'h10_0000;
    localparam logic [63:0]        PRESS_SCALE  = 64'd3125;

endpackage

[rtl/core/baro_trim_compensation.sv]
// Barometer trim compensation top level: trim registers, front end, divider, pressure tail.
// Depends on btc_pkg, btc_front and btc_div.
//
//  channel  | valid        | ready        | payload
//  ---------+--------------+--------------+-----------------------------------------------
//  input    | i_in_valid   | o_in_ready   | i_raw_temperature, i_raw_pressure
//  result   | o_out_valid  | i_out_ready  | o_temperature_centi, o_fine_temperature,
//           |              |              | o_pressure_q24_8, o_pressure_valid
//  config   | i_cfg_valid  | o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One conversion pair per cycle while the result side accepts; 10 front stages, 64 divider
// stages, one quotient bit each, and 6 tail stages including the output register.
// Synchronous active-low reset clears valid bits and trim registers.
// Each stage loads when empty or when the stage after it moves, so bubbles close up
// and a stalled result does not block new transfers while earlier stages have room.
module baro_trim_compensation (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [19:0]        i_raw_temperature,
    input  logic [19:0]        i_raw_pressure,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [14:0] o_temperature_centi,
    output logic signed [31:0] o_fine_temperature,
    output logic [31:0]        o_pressure_q24_8,
    output logic               o_pressure_valid,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [7:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data
);

    localparam int NS = btc_pkg::POST_STAGES;

    // trim registers
    logic [47:0] r_temp_trim;
    logic [63:0] r_press_low, r_press_high;
    logic [15:0] r_press_last;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_trim  <= '0;
            r_press_low  <= '0;
            r_press_high <= '0;
            r_press_last <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                btc_pkg::CFG_TEMP_TRIM:  r_temp_trim  <= i_cfg_data[47:0];
                btc_pkg::CFG_PRESS_LOW:  r_press_low  <= i_cfg_data;
                btc_pkg::CFG_PRESS_HIGH: r_press_high <= i_cfg_data;
                btc_pkg::CFG_PRESS_LAST: r_press_last <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    btc_pkg::t_trim trim;

    assign trim.t1 = r_temp_trim[15:0];
    assign trim.t2 = r_temp_trim[31:16];
    assign trim.t3 = r_temp_trim[47:32];
    assign trim.p1 = r_press_low[15:0];
    assign trim.p2 = r_press_low[31:16];
    assign trim.p3 = r_press_low[47:32];
    assign trim.p4 = r_press_low[63:48];
    assign trim.p5 = r_press_high[15:0];
    assign trim.p6 = r_press_high[31:16];
    assign trim.p7 = r_press_high[47:32];
    assign trim.p8 = r_press_high[63:48];
    assign trim.p9 = r_press_last;

    // front end
    logic           f_valid, f_ready, f_neg;
    logic [63:0]    f_num;
    logic [30:0]    f_den;
    btc_pkg::t_side f_side;

    btc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_trim  (trim),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_adc_t (i_raw_temperature),
        .i_adc_p (i_raw_pressure),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_num   (f_num),
        .o_den   (f_den),
        .o_neg   (f_neg),
        .o_side  (f_side)
    );

    // divider
    logic           d_valid, d_neg;
    logic [63:0]    d_quot;
    btc_pkg::t_side d_side;
    logic [NS+1:1]  en;

    btc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_num   (f_num),
        .i_den   (f_den),
        .i_neg   (f_neg),
        .i_side  (f_side),
        .o_valid (d_valid),
        .i_ready (en[1]),
        .o_quot  (d_quot),
        .o_neg   (d_neg),
        .o_side  (d_side)
    );

    // pressure tail
    logic [NS:1] r_v;

    always_comb begin
        en[NS+1] = i_out_ready;
        for (int k = NS; k >= 1; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[1]) begin
                r_v[1] <= d_valid;
            end
            for (int k = 2; k <= NS; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // stage 1: signed quotient
    logic signed [63:0] r1_p;
    btc_pkg::t_side     r1_side;

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r1_p    <= d_neg ? $signed(64'd0 - d_quot) : $signed(d_quot);
            r1_side <= d_side;
        end
    end

    // stage 2: s*s split into 32-bit partial products, p8 term
    logic signed [63:0] s2_s;
    logic [63:0]        s2_hl;
    logic [63:0]        r2_ll;
    logic [31:0]        r2_hl;
    logic signed [63:0] r2_w2, r2_p;
    btc_pkg::t_side     r2_side;

    assign s2_s  = r1_p >>> 13;
    assign s2_hl = 64'(s2_s[31:0]) * 64'(s2_s[63:32]);

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r2_ll   <= 64'(s2_s[31:0]) * 64'(s2_s[31:0]);
            r2_hl   <= s2_hl[31:0];
            r2_w2   <= r1_p * 64'(trim.p8);
            r2_p    <= r1_p;
            r2_side <= r1_side;
        end
    end

    // stage 3: cross term counts twice
    logic [63:0]        r3_ss;
    logic signed [63:0] r3_w2, r3_p;
    btc_pkg::t_side     r3_side;

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r3_ss   <= r2_ll + {r2_hl[30:0], 1'b0, 32'b0};
            r3_w2   <= r2_w2;
            r3_p    <= r2_p;
            r3_side <= r2_side;
        end
    end

    // stage 4: p9 term
    logic signed [63:0] r4_w1, r4_w2, r4_p;
    btc_pkg::t_side     r4_side;

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r4_w1   <= $signed(r3_ss) * 64'(trim.p9);
            r4_w2   <= r3_w2;
            r4_p    <= r3_p;
            r4_side <= r3_side;
        end
    end

    // stage 5
    logic signed [63:0] r5_sum;
    btc_pkg::t_side     r5_side;

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r5_sum  <= r4_p + (r4_w1 >>> 25) + (r4_w2 >>> 19);
            r5_side <= r4_side;
        end
    end

    // stage 6: p7 offset, clamp to 32 bits, output register
    logic signed [63:0] s6_fin;
    logic [31:0]        s6_sat;

    assign s6_fin = (r5_sum >>> 8) + (64'(trim.p7) <<< 4);

    always_comb begin
        if (s6_fin[63]) begin
            s6_sat = '0;
        end else if (s6_fin[62:32] != '0) begin
            s6_sat = '1;
        end else begin
            s6_sat = s6_fin[31:0];
        end
    end

    logic signed [14:0] r6_tcs;
    logic signed [31:0] r6_tfine;
    logic [31:0]        r6_press;
    logic               r6_pvalid;

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r6_tcs    <= r5_side.tcs;
            r6_tfine  <= r5_side.tfine;
            r6_press  <= r5_side.zero ? 32'd0 : s6_sat;
            r6_pvalid <= !r5_side.zero;
        end
    end

    assign o_out_valid         = r_v[NS];
    assign o_temperature_centi = r6_tcs;
    assign o_fine_temperature  = r6_tfine;
    assign o_pressure_q24_8    = r6_press;
    assign o_pressure_valid    = r6_pvalid;

`ifndef SYNTHESIS
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_pressure_valid |-> o_pressure_q24_8 == 32'd0)
        else $error("pressure not zero with zero divisor");

    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_temperature_centi >= btc_pkg::TEMP_MIN
                     && o_temperature_centi <= btc_pkg::TEMP_MAX)
        else $error("temperature outside saturation range");

    a_ready_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> o_in_ready)
        else $error("input stalled while result side is free");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");
`endif

endmodule

[rtl/core/btc_front.sv]
// Temperature compensation and pressure numerator / divisor preparation.
// Ten register stages; depends on btc_pkg.
module btc_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  btc_pkg::t_trim        i_trim,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [19:0]           i_adc_t,
    input  logic [19:0]           i_adc_p,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [63:0]           o_num,
    output logic [30:0]           o_den,
    output logic                  o_neg,
    output btc_pkg::t_side        o_side
);

    localparam int NS = btc_pkg::FRONT_STAGES;

    logic [NS:1]   r_v;
    logic [NS+1:1] en;

    always_comb begin
        en[NS+1] = i_ready;
        for (int k = NS; k >= 1; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_ready = en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[1]) begin
                r_v[1] <= i_valid;
            end
            for (int k = 2; k <= NS; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // stage 1
    logic signed [17:0] s1_dx;
    logic signed [16:0] s1_d;
    logic signed [33:0] s1_ta, s1_dd;
    logic signed [33:0] r1_ta;
    logic [31:0]        r1_dd;
    logic [19:0]        r1_adcp;

    assign s1_dx = $signed({1'b0, i_adc_t[19:3]}) - $signed({1'b0, i_trim.t1, 1'b0});
    assign s1_d  = $signed({1'b0, i_adc_t[19:4]}) - $signed({1'b0, i_trim.t1});
    assign s1_ta = 34'(s1_dx) * 34'(i_trim.t2);
    assign s1_dd = 34'(s1_d) * 34'(s1_d);

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r1_ta   <= s1_ta;
            r1_dd   <= s1_dd[31:0];
            r1_adcp <= i_adc_p;
        end
    end

    // stage 2
    logic signed [22:0] r2_a;
    logic signed [36:0] r2_b1;
    logic [19:0]        r2_adcp;

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r2_a    <= 23'(r1_ta >>> 11);
            r2_b1   <= 37'($signed({1'b0, r1_dd[31:12]})) * 37'(i_trim.t3);
            r2_adcp <= r1_adcp;
        end
    end

    // stage 3: fine temperature
    logic signed [23:0] r3_tfine;
    logic [19:0]        r3_adcp;

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r3_tfine <= 24'(r2_a) + 24'(r2_b1 >>> 14);
            r3_adcp  <= r2_adcp;
        end
    end

    // stage 4: centidegrees with saturation, pressure offset
    logic signed [27:0] s4_tc;
    logic signed [14:0] s4_tcs;
    logic signed [14:0] r4_tcs;
    logic signed [23:0] r4_tfine;
    logic signed [24:0] r4_v1;
    logic [19:0]        r4_adcp;

    assign s4_tc = (28'(r3_tfine) * 28'sd5 + 28'sd128) >>> 8;

    always_comb begin
        if (s4_tc < 28'(btc_pkg::TEMP_MIN)) begin
            s4_tcs = btc_pkg::TEMP_MIN;
        end else if (s4_tc > 28'(btc_pkg::TEMP_MAX)) begin
            s4_tcs = btc_pkg::TEMP_MAX;
        end else begin
            s4_tcs = 15'(s4_tc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r4_tcs   <= s4_tcs;
            r4_tfine <= r3_tfine;
            r4_v1    <= 25'(r3_tfine) - btc_pkg::TFINE_OFFSET;
            r4_adcp  <= r3_adcp;
        end
    end

    // stage 5
    logic signed [49:0] r5_sq;
    logic signed [40:0] r5_vp5, r5_vp2;
    logic signed [14:0] r5_tcs;
    logic signed [23:0] r5_tfine;
    logic [19:0]        r5_adcp;

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r5_sq    <= 50'(r4_v1) * 50'(r4_v1);
            r5_vp5   <= 41'(r4_v1) * 41'(i_trim.p5);
            r5_vp2   <= 41'(r4_v1) * 41'(i_trim.p2);
            r5_tcs   <= r4_tcs;
            r5_tfine <= r4_tfine;
            r5_adcp  <= r4_adcp;
        end
    end

    // stage 6: products wrap at 64 bits
    logic signed [63:0] r6_x6, r6_x3;
    logic signed [40:0] r6_vp5, r6_vp2;
    logic signed [14:0] r6_tcs;
    logic signed [23:0] r6_tfine;
    logic [19:0]        r6_adcp;

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r6_x6    <= 64'(r5_sq) * 64'(i_trim.p6);
            r6_x3    <= 64'(r5_sq) * 64'(i_trim.p3);
            r6_vp5   <= r5_vp5;
            r6_vp2   <= r5_vp2;
            r6_tcs   <= r5_tcs;
            r6_tfine <= r5_tfine;
            r6_adcp  <= r5_adcp;
        end
    end

    // stage 7
    logic [20:0]        s7_pd;
    logic signed [63:0] r7_v2, r7_v1c;
    logic [63:0]        r7_np;
    logic signed [14:0] r7_tcs;
    logic signed [23:0] r7_tfine;

    assign s7_pd = btc_pkg::PRESS_FULL - {1'b0, r6_adcp};

    always_ff @(posedge i_clk) begin
        if (en[7]) begin
            r7_v2    <= r6_x6 + (64'(r6_vp5) <<< 17) + (64'(i_trim.p4) <<< 35);
            r7_v1c   <= (r6_x3 >>> 8) + (64'(r6_vp2) <<< 12) + btc_pkg::V1_BIAS;
            r7_np    <= {12'b0, s7_pd, 31'b0};
            r7_tcs   <= r6_tcs;
            r7_tfine <= r6_tfine;
        end
    end

    // stage 8
    logic [63:0]        r8_n1, r8_m1;
    logic signed [14:0] r8_tcs;
    logic signed [23:0] r8_tfine;

    always_ff @(posedge i_clk) begin
        if (en[8]) begin
            r8_n1    <= r7_np - r7_v2;
            r8_m1    <= r7_v1c * {48'b0, i_trim.p1};
            r8_tcs   <= r7_tcs;
            r8_tfine <= r7_tfine;
        end
    end

    // stage 9: numerator scale, divisor is the top 31 bits
    logic [63:0]        r9_num;
    logic signed [30:0] r9_den;
    logic signed [14:0] r9_tcs;
    logic signed [23:0] r9_tfine;

    always_ff @(posedge i_clk) begin
        if (en[9]) begin
            r9_num   <= r8_n1 * btc_pkg::PRESS_SCALE;
            r9_den   <= 31'($signed(r8_m1) >>> 33);
            r9_tcs   <= r8_tcs;
            r9_tfine <= r8_tfine;
        end
    end

    // stage 10: magnitudes and quotient sign
    logic [63:0]    r10_num;
    logic [30:0]    r10_den;
    logic           r10_neg;
    btc_pkg::t_side r10_side;

    always_ff @(posedge i_clk) begin
        if (en[10]) begin
            r10_num        <= r9_num[63] ? (64'd0 - r9_num) : r9_num;
            r10_den        <= r9_den[30] ? 31'(-r9_den) : 31'(r9_den);
            r10_neg        <= r9_num[63] ^ r9_den[30];
            r10_side.tcs   <= r9_tcs;
            r10_side.tfine <= 32'(r9_tfine);
            r10_side.zero  <= (r9_den == '0);
        end
    end

    assign o_valid = r_v[NS];
    assign o_num   = r10_num;
    assign o_den   = r10_den;
    assign o_neg   = r10_neg;
    assign o_side  = r10_side;

endmodule

[rtl/core/btc_div.sv]
// Pipelined restoring divider, 64-bit dividend by 31-bit divisor, one bit a stage.
// Carries sign and side results along; depends on btc_pkg.
module btc_div (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [63:0]    i_num,
    input  logic [30:0]    i_den,
    input  logic           i_neg,
    input  btc_pkg::t_side i_side,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [63:0]    o_quot,
    output logic           o_neg,
    output btc_pkg::t_side o_side
);

    localparam int NS = btc_pkg::DIV_STEPS;

    logic [NS-1:0]  r_v;
    logic [NS:0]    en;
    logic [30:0]    r_rem  [NS];
    logic [63:0]    r_acc  [NS];
    logic [30:0]    r_den  [NS];
    logic           r_neg  [NS];
    btc_pkg::t_side r_side [NS];

    always_comb begin
        en[NS] = i_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_ready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    for (genvar k = 0; k < NS; k++) begin : g_step
        logic [30:0]    src_rem;
        logic [63:0]    src_acc;
        logic [30:0]    src_den;
        logic           src_neg;
        btc_pkg::t_side src_side;
        logic [31:0]    cat;
        logic           ge;

        if (k == 0) begin : g_first
            assign src_rem  = '0;
            assign src_acc  = i_num;
            assign src_den  = i_den;
            assign src_neg  = i_neg;
            assign src_side = i_side;
        end else begin : g_next
            assign src_rem  = r_rem[k-1];
            assign src_acc  = r_acc[k-1];
            assign src_den  = r_den[k-1];
            assign src_neg  = r_neg[k-1];
            assign src_side = r_side[k-1];
        end

        // quotient bits shift in as dividend bits shift out
        assign cat = {src_rem, src_acc[63]};
        assign ge  = (cat >= {1'b0, src_den});

        always_ff @(posedge i_clk) begin
            if (en[k]) begin
                r_rem[k]  <= ge ? 31'(cat - {1'b0, src_den}) : cat[30:0];
                r_acc[k]  <= {src_acc[62:0], ge};
                r_den[k]  <= src_den;
                r_neg[k]  <= src_neg;
                r_side[k] <= src_side;
            end
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_quot  = r_acc[NS-1];
    assign o_neg   = r_neg[NS-1];
    assign o_side  = r_side[NS-1];

endmodule

[verif/btc_checker.sv]
// Checker for baro_trim_compensation: watches the config, input and result channels,
// predicts each result from its own copy of the trim registers and compares field by field.
// Depends on btc_pkg for the register indexes.
module btc_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [19:0]        i_raw_temperature,
    input  logic [19:0]        i_raw_pressure,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic signed [14:0] i_temperature_centi,
    input  logic signed [31:0] i_fine_temperature,
    input  logic [31:0]        i_pressure_q24_8,
    input  logic               i_pressure_valid,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [7:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct packed {
        logic signed [14:0] centi;
        logic signed [31:0] tfine;
        logic [31:0]        press;
        logic               pvalid;
    } t_comp;

    logic [47:0] temp_trim;
    logic [63:0] press_lo;
    logic [63:0] press_hi;
    logic [15:0] press_last;
    t_comp       awaited_q[$];

    function automatic logic [63:0] sx16(logic [15:0] w);
        return {{48{w[15]}}, w};
    endfunction

    function automatic logic [63:0] asr(logic [63:0] x, int n);
        return $signed(x) >>> n;
    endfunction

    // truncating signed divide on 64-bit patterns, divisor nonzero
    function automatic logic [63:0] sdiv(logic [63:0] a, logic [63:0] b);
        logic [63:0] ma, mb, q;
        ma = a[63] ? -a : a;
        mb = b[63] ? -b : b;
        q  = ma / mb;
        return (a[63] != b[63]) ? -q : q;
    endfunction

    function automatic t_comp compensate(logic [19:0] raw_t, logic [19:0] raw_p);
        logic [63:0] adc_t, adc_p, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [63:0] a, d, b, tf, tc, v1, v2, p, s, w1, w2;
        t_comp r;
        adc_t = {44'd0, raw_t};
        adc_p = {44'd0, raw_p};
        t1 = {48'd0, temp_trim[15:0]};
        t2 = sx16(temp_trim[31:16]);
        t3 = sx16(temp_trim[47:32]);
        p1 = {48'd0, press_lo[15:0]};
        p2 = sx16(press_lo[31:16]);
        p3 = sx16(press_lo[47:32]);
        p4 = sx16(press_lo[63:48]);
        p5 = sx16(press_hi[15:0]);
        p6 = sx16(press_hi[31:16]);
        p7 = sx16(press_hi[47:32]);
        p8 = sx16(press_hi[63:48]);
        p9 = sx16(press_last);

        a  = asr(((adc_t >> 3) - (t1 << 1)) * t2, 11);
        d  = (adc_t >> 4) - t1;
        b  = asr(asr(d * d, 12) * t3, 14);
        tf = a + b;
        tc = asr(tf * 64'd5 + 64'd128, 8);
        if ($signed(tc) < -64'sd4000)
            r.centi = btc_pkg::TEMP_MIN;
        else if ($signed(tc) > 64'sd8500)
            r.centi = btc_pkg::TEMP_MAX;
        else
            r.centi = tc[14:0];
        r.tfine = tf[31:0];

        v1 = tf - 64'd128000;
        v2 = v1 * v1 * p6;
        v2 = v2 + ((v1 * p5) << 17);
        v2 = v2 + (p4 << 35);
        v1 = asr(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
        v1 = asr((64'h0000_8000_0000_0000 + v1) * p1, 33);

        r.press  = '0;
        r.pvalid = 1'b0;
        if (v1 != 0) begin
            p  = 64'd1048576 - adc_p;
            p  = sdiv(((p << 31) - v2) * 64'd3125, v1);
            s  = asr(p, 13);
            w1 = asr(p9 * s * s, 25);
            w2 = asr(p8 * p, 19);
            p  = asr(p + w1 + w2, 8) + (p7 << 4);
            if (p[63])
                r.press = '0;
            else if (p > 64'hFFFF_FFFF)
                r.press = '1;
            else
                r.press = p[31:0];
            r.pvalid = 1'b1;
        end
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("[%0t] result %s: got %0h, expected %0h", $realtime, field, got, want);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        t_comp want;
        if (!i_rst_n) begin
            temp_trim  <= '0;
            press_lo   <= '0;
            press_hi   <= '0;
            press_last <= '0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    btc_pkg::CFG_TEMP_TRIM:  temp_trim  <= i_cfg_data[47:0];
                    btc_pkg::CFG_PRESS_LOW:  press_lo   <= i_cfg_data;
                    btc_pkg::CFG_PRESS_HIGH: press_hi   <= i_cfg_data;
                    btc_pkg::CFG_PRESS_LAST: press_last <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                awaited_q.push_back(compensate(i_raw_temperature, i_raw_pressure));
                o_pending++;
            end
            if (i_out_valid && i_out_ready) begin
                if (awaited_q.size() == 0) begin
                    $display("[%0t] result transfer with nothing outstanding", $realtime);
                    o_fail_count++;
                end else begin
                    want = awaited_q.pop_front();
                    o_pending--;
                    if (i_temperature_centi !== want.centi)
                        report_mismatch("temperature_centi", 64'(i_temperature_centi),
                                        64'(want.centi));
                    if (i_fine_temperature !== want.tfine)
                        report_mismatch("fine_temperature", 64'(i_fine_temperature),
                                        64'(want.tfine));
                    if (i_pressure_q24_8 !== want.press)
                        report_mismatch("pressure_q24_8", 64'(i_pressure_q24_8),
                                        64'(want.press));
                    if (i_pressure_valid !== want.pvalid)
                        report_mismatch("pressure_valid", 64'(i_pressure_valid),
                                        64'(want.pvalid));
                end
            end
        end
    end

endmodule

[verif/tb_top.sv]
// Top of the baro_trim_compensation testbench: clock, reset, config writes, conversion
// stimulus, result back-pressure, watchdog and verdict. Depends on btc_pkg and btc_checker.
module tb_top;

    localparam logic [7:0] CFG_SPARE_LO = 8'd4;    // beyond the register list
    localparam logic [7:0] CFG_SPARE_HI = 8'hFF;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 3000;
    localparam int SETTLE      = 120;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [19:0]        raw_t = '0;
    logic [19:0]        raw_p = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [14:0] temp_centi;
    logic signed [31:0] fine_temp;
    logic [31:0]        press_q;
    logic               press_ok;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [7:0]         cfg_index = '0;
    logic [63:0]        cfg_data = '0;
    int                 fail_count;
    int                 pending;

    int send_idle = 0;
    int recv_idle = 0;
    logic hold_go = 1'b0;
    int   hold_left = 0;
    int   quiet_cycles = 0;

    baro_trim_compensation u_top (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_raw_temperature(raw_t), .i_raw_pressure(raw_p),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_temperature_centi(temp_centi), .o_fine_temperature(fine_temp),
        .o_pressure_q24_8(press_q), .o_pressure_valid(press_ok),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    btc_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_raw_temperature(raw_t), .i_raw_pressure(raw_p),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_temperature_centi(temp_centi), .i_fine_temperature(fine_temp),
        .i_pressure_q24_8(press_q), .i_pressure_valid(press_ok),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    // result side back-pressure; a long hold-off is counted here
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_go && hold_left == 0) begin
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end else if (hold_left > 1) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            if (hold_left == 1)
                hold_left <= -1;    // hold done, not rearmed
            out_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic write_reg(logic [7:0] idx, logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_trims(logic [47:0] tt, logic [63:0] lo, logic [63:0] hi,
                              logic [15:0] last);
        write_reg(btc_pkg::CFG_TEMP_TRIM, {16'hDEAD, tt});   // upper bits must be dropped
        write_reg(btc_pkg::CFG_PRESS_LOW, lo);
        write_reg(btc_pkg::CFG_PRESS_HIGH, hi);
        write_reg(btc_pkg::CFG_PRESS_LAST, {48'hBEEF_0000_0000, last});
    endtask

    task automatic send_pair(logic [19:0] t, logic [19:0] p);
        if ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle);
        end
        in_valid <= 1'b1;
        raw_t    <= t;
        raw_p    <= p;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // stop offering, let every result arrive, then give the pipeline time to empty
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic send_random_pair();
        if ($urandom_range(99) < 75)
            send_pair(20'($urandom_range(600000, 400000)), 20'($urandom_range(450000, 250000)));
        else
            send_pair(20'($urandom), 20'($urandom));
    endtask

    // typical trims with a little random spread
    task automatic load_typical_trims();
        logic [15:0] w[12];
        w = '{16'd27504, 16'd26435, -16'sd1000, 16'd36477, -16'sd10685, 16'd3024,
              16'd2855, 16'd140, -16'sd7, 16'd15500, -16'sd14600, 16'd6000};
        foreach (w[k]) w[k] = w[k] + 16'($urandom_range(64)) - 16'd32;
        load_trims({w[2], w[1], w[0]}, {w[6], w[5], w[4], w[3]},
                   {w[10], w[9], w[8], w[7]}, w[11]);
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset trims: P1 is zero so the divisor is zero
        send_pair(20'h00000, 20'h00000);
        send_pair(20'hFFFFF, 20'hFFFFF);
        drain_results();

        load_typical_trims();
        write_reg(CFG_SPARE_LO, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_SPARE_HI, 64'h0);
        send_pair(20'd519888, 20'd415148);
        send_pair(20'h00000, 20'hFFFFF);
        send_pair(20'hFFFFF, 20'h00000);
        send_pair(20'hAAAAA, 20'h55555);
        send_pair(20'h55555, 20'hAAAAA);
        send_pair(20'd700000, 20'd300000);   // hot end
        send_pair(20'd300000, 20'd500000);   // cold end saturates
        drain_results();

        // all-ones trims: extreme coefficients, overflowing intermediates
        load_trims('1, '1, '1, '1);
        send_pair(20'hFFFFF, 20'h00001);
        send_pair(20'h00010, 20'h80000);
        drain_results();

        // sign-bit trims, P5 to P8 at the positive maximum
        load_trims({3{16'h8000}}, {4{16'h8000}}, {4{16'h7FFF}}, 16'h8000);
        send_pair(20'h80000, 20'h7FFFF);
        send_pair(20'h00000, 20'hFFFFF);
        drain_results();

        // typical trims except P1 zero: divisor zero, temperature still valid
        load_trims({-16'sd1000, 16'd26435, 16'd27504}, 64'h0B27_0BD0_D643_0000,
                   {-16'sd14600, 16'd15500, -16'sd7, 16'd140}, 16'd6000);
        send_pair(20'd519888, 20'd415148);
        drain_results();

        // the held block offers more items than the pipeline holds, so the input stalls
        for (int ph = 0; ph < 3; ph++) begin
            send_idle = (ph == 0) ? 27 : (ph == 1) ? 82 : 0;
            recv_idle = (ph == 0) ? 82 : (ph == 1) ? 27 : 0;
            for (int blk = 0; blk < 3; blk++) begin
                if (ph == 1 && blk == 2)
                    load_trims(48'($urandom) << 16 | 48'($urandom),
                               {$urandom, $urandom}, {$urandom, $urandom}, 16'($urandom));
                else
                    load_typical_trims();
                for (int n = 0; n < ((ph == 2 && blk == 0) ? 120 : 34); n++) begin
                    if (ph == 2 && blk == 0 && n == 4)
                        hold_go <= 1'b1;
                    send_random_pair();
                end
                drain_results();
            end
        end

        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
